FILE: rtl/boot_keyboard_report_differ_unit_defines.svh
// ----------------------------------------------------------------------------
// boot_keyboard_report_differ_unit_defines.svh
// Assertion macros used by the report differ top level.
// ----------------------------------------------------------------------------
`ifndef BOOT_KEYBOARD_REPORT_DIFFER_UNIT_DEFINES_SVH
`define BOOT_KEYBOARD_REPORT_DIFFER_UNIT_DEFINES_SVH

// Same-cycle implication, quiet during reset
`define BKRD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset
`define BKRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bkrd_pkg.sv
// ----------------------------------------------------------------------------
// bkrd_pkg
// Types, constants and helpers for the boot keyboard report differ.
// ----------------------------------------------------------------------------
package bkrd_pkg;

  localparam int KEY_SLOTS = 6;
  localparam int CODE_W    = 8;
  localparam int SLOT_W    = 3;
  localparam int KIND_W    = 2;

  // Event kinds
  localparam logic [KIND_W-1:0] KIND_MODS    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;

  typedef logic [KEY_SLOTS-1:0][CODE_W-1:0] key_vec_t;
  typedef logic [KEY_SLOTS-1:0]             slot_mask_t;

  // One boot report as it arrives
  typedef struct packed {
    logic [CODE_W-1:0] modifier_bits;
    logic [CODE_W-1:0] key_code_0;
    logic [CODE_W-1:0] key_code_1;
    logic [CODE_W-1:0] key_code_2;
    logic [CODE_W-1:0] key_code_3;
    logic [CODE_W-1:0] key_code_4;
    logic [CODE_W-1:0] key_code_5;
  } report_t;

  // One event as it leaves
  typedef struct packed {
    logic [KIND_W-1:0] event_kind;
    logic [CODE_W-1:0] event_code;
    logic [SLOT_W-1:0] slot_index;
    logic              last_event;
  } event_t;

  // What the lanes found for one report, handed to the merge stage
  typedef struct packed {
    logic              mods_chg;
    logic [CODE_W-1:0] mods;
    key_vec_t          new_keys;
    key_vec_t          old_keys;
    slot_mask_t        press;
    slot_mask_t        release_m;
  } pend_load_t;

  // Slot view of a report's keycodes
  function automatic key_vec_t report_keys(report_t r);
    key_vec_t k;
    k[0] = r.key_code_0;
    k[1] = r.key_code_1;
    k[2] = r.key_code_2;
    k[3] = r.key_code_3;
    k[4] = r.key_code_4;
    k[5] = r.key_code_5;
    return k;
  endfunction

endpackage

FILE: rtl/bkrd_lane.sv
// ----------------------------------------------------------------------------
// bkrd_lane
// One key slot: decides press (new code absent from old report) and
// release (old code absent from new report).
// ----------------------------------------------------------------------------
module bkrd_lane (
  input  logic [bkrd_pkg::CODE_W-1:0] new_key,
  input  logic [bkrd_pkg::CODE_W-1:0] old_key,
  input  bkrd_pkg::key_vec_t          new_keys,
  input  bkrd_pkg::key_vec_t          old_keys,
  output logic                        press,
  output logic                        release_f
);
  import bkrd_pkg::*;

  logic in_old;
  logic in_new;

  // Membership search over the other report, one compare per slot
  always_comb begin
    in_old = 1'b0;
    in_new = 1'b0;
    for (int j = 0; j < KEY_SLOTS; j++) begin
      if (old_keys[j] == new_key) in_old = 1'b1;
      if (new_keys[j] == old_key) in_new = 1'b1;
    end
  end

  // Empty slots never give an event
  assign press     = (new_key != '0) && !in_old;
  assign release_f = (old_key != '0) && !in_new;

endmodule

FILE: rtl/bkrd_merge.sv
// ----------------------------------------------------------------------------
// bkrd_merge
// Holds one report's lane findings; unless stalled, issues its events one
// per cycle into an output register: modifiers, then presses, then releases.
// ----------------------------------------------------------------------------
module bkrd_merge (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load_valid,
  input  bkrd_pkg::pend_load_t load_data,
  output logic                 load_ready,
  output logic                 evt_valid,
  input  logic                 evt_ready,
  output bkrd_pkg::event_t     evt
);
  import bkrd_pkg::*;

  // Pending masks (control) and codes (payload)
  logic              mods_pend;
  slot_mask_t        press_pend;
  slot_mask_t        release_pend;
  logic [CODE_W-1:0] mods_code;
  key_vec_t          new_keys;
  key_vec_t          old_keys;

  logic              pend_any;
  logic              pop;
  logic              pick_last;
  logic [SLOT_W-1:0] idx;
  logic              mods_rem;
  slot_mask_t        press_rem;
  slot_mask_t        release_rem;
  event_t            pick;

  // Pick the next event in priority order and clear it
  always_comb begin
    idx         = '0;
    mods_rem    = mods_pend;
    press_rem   = press_pend;
    release_rem = release_pend;
    pick        = '0;
    if (mods_pend) begin
      mods_rem        = 1'b0;
      pick.event_kind = KIND_MODS;
      pick.event_code = mods_code;
    end else if (|press_pend) begin
      for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
        if (press_pend[i]) idx = SLOT_W'(i);
      end
      press_rem[idx]  = 1'b0;
      pick.event_kind = KIND_PRESS;
      pick.event_code = new_keys[idx];
      pick.slot_index = idx;
    end else begin
      for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
        if (release_pend[i]) idx = SLOT_W'(i);
      end
      release_rem[idx] = 1'b0;
      pick.event_kind  = KIND_RELEASE;
      pick.event_code  = old_keys[idx];
      pick.slot_index  = idx;
    end
    pick_last       = !mods_rem && (press_rem == '0) && (release_rem == '0);
    pick.last_event = pick_last;
  end

  assign pend_any   = mods_pend || (|press_pend) || (|release_pend);
  assign pop        = pend_any && (!evt_valid || evt_ready);
  assign load_ready = !pend_any || (pop && pick_last);

  // Pending store: load a new report or retire the issued event
  always_ff @(posedge clk) begin
    if (rst) begin
      mods_pend    <= 1'b0;
      press_pend   <= '0;
      release_pend <= '0;
    end else if (load_valid && load_ready) begin
      mods_pend    <= load_data.mods_chg;
      press_pend   <= load_data.press;
      release_pend <= load_data.release_m;
    end else if (pop) begin
      mods_pend    <= mods_rem;
      press_pend   <= press_rem;
      release_pend <= release_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      mods_code <= load_data.mods;
      new_keys  <= load_data.new_keys;
      old_keys  <= load_data.old_keys;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (pop) begin
      evt_valid <= 1'b1;
    end else if (evt_ready) begin
      evt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) evt <= pick;
  end

endmodule

FILE: rtl/boot_keyboard_report_differ_unit.sv
// ----------------------------------------------------------------------------
// boot_keyboard_report_differ_unit
// Compares each boot keyboard report with the previous one and emits
// modifier, key-pressed and key-released events.
// ----------------------------------------------------------------------------
//  channel | signals                 | direction | payload
//  --------+-------------------------+-----------+----------------------
//  req     | req_valid / req_ready   | in        | report_t (report)
//  evt     | evt_valid / evt_ready   | out       | event_t (one event)
//
//  A report is compared combinationally by KEY_SLOTS parallel lanes.
//  Its findings are registered in the pending store, from which its first
//  event moves into the output register. The output issues one event per
//  cycle unless stalled; a report with events holds the merge stage until
//  its last event issues. The next report is taken in the cycle its
//  predecessor's last event leaves the pending store. Output stalls hold
//  the pending store. Reset zeroes the held report and drops pending events.
// ----------------------------------------------------------------------------
`include "boot_keyboard_report_differ_unit_defines.svh"

module boot_keyboard_report_differ_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  bkrd_pkg::report_t req,
  output logic              evt_valid,
  input  logic              evt_ready,
  output bkrd_pkg::event_t  evt
);
  import bkrd_pkg::*;

  // Previous report
  logic [CODE_W-1:0] held_mods;
  key_vec_t          held_keys;

  key_vec_t   in_keys;
  slot_mask_t press;
  slot_mask_t release_m;
  pend_load_t load_data;
  logic       load_valid;
  logic       req_xfer;

  assign in_keys  = report_keys(req);
  assign req_xfer = req_valid && req_ready;

  // Per-slot lanes
  for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
    bkrd_lane u_lane (
      .new_key   (in_keys[g]),
      .old_key   (held_keys[g]),
      .new_keys  (in_keys),
      .old_keys  (held_keys),
      .press     (press[g]),
      .release_f (release_m[g])
    );
  end

  // Lane findings for the merge stage
  always_comb begin
    load_data.mods_chg  = (req.modifier_bits != held_mods);
    load_data.mods      = req.modifier_bits;
    load_data.new_keys  = in_keys;
    load_data.old_keys  = held_keys;
    load_data.press     = press;
    load_data.release_m = release_m;
  end

  assign load_valid = req_valid && (load_data.mods_chg || (|press) || (|release_m));

  bkrd_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .load_valid (load_valid),
    .load_data  (load_data),
    .load_ready (req_ready),
    .evt_valid  (evt_valid),
    .evt_ready  (evt_ready),
    .evt        (evt)
  );

  // Held report replaced on every transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      held_mods <= '0;
      held_keys <= '0;
    end else if (req_xfer) begin
      held_mods <= req.modifier_bits;
      held_keys <= in_keys;
    end
  end

  // Checks
  `BKRD_ASSERT_IMPL(a_kind_valid, clk, rst, evt_valid,
                    evt.event_kind != KIND_UNUSED, "reserved event kind issued")
  `BKRD_ASSERT_IMPL(a_mods_slot, clk, rst, evt_valid && (evt.event_kind == KIND_MODS),
                    evt.slot_index == '0, "modifier event with nonzero slot")
  `BKRD_ASSERT_NEXT(a_held_upd, clk, rst, req_xfer,
                    (held_mods == $past(req.modifier_bits)) && (held_keys == $past(in_keys)),
                    "held report not replaced")

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the boot keyboard report differ. Reports are sent
// over the request channel. A predictor keeps its own copy of the held report
// and queues the modifier, press and release events that each report should
// produce. Every event transfer is checked field by field against the oldest
// event still due. Directed cases come first, then a long output hold-off,
// then random typing sequences mixed with noise.
// ----------------------------------------------------------------------------
module tb;
  import bkrd_pkg::*;

  typedef logic [CODE_W-1:0] slot_codes_t [KEY_SLOTS];

  logic    clk;
  logic    rst;
  logic    req_valid;
  logic    req_ready;
  report_t report_in;
  logic    evt_valid;
  logic    evt_ready;
  event_t  event_out;

  // Predictor state: the report the block should be holding
  logic [CODE_W-1:0] held_mods;
  slot_codes_t       held_keys;
  report_t           last_report;

  event_t keyboard_events_due[$];
  event_t want_evt;

  int  error_count;
  int  reports_sent;
  int  events_seen;
  int  longest_run;
  int  input_stall_cycles;
  bit  idle_on;
  bit  stalls_on;
  int  hold_left;
  int  stall_left;

  boot_keyboard_report_differ_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (report_in),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .evt       (event_out)
  );

  // Clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic slot_codes_t codes_of(report_t r);
    slot_codes_t c;
    c[0] = r.key_code_0;
    c[1] = r.key_code_1;
    c[2] = r.key_code_2;
    c[3] = r.key_code_3;
    c[4] = r.key_code_4;
    c[5] = r.key_code_5;
    return c;
  endfunction

  function automatic report_t make_report(logic [CODE_W-1:0] mods, slot_codes_t c);
    report_t r;
    r.modifier_bits = mods;
    r.key_code_0    = c[0];
    r.key_code_1    = c[1];
    r.key_code_2    = c[2];
    r.key_code_3    = c[3];
    r.key_code_4    = c[4];
    r.key_code_5    = c[5];
    return r;
  endfunction

  function automatic bit code_present(slot_codes_t c, logic [CODE_W-1:0] code);
    foreach (c[i]) begin
      if (c[i] == code) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic event_t mk_event(logic [KIND_W-1:0] kind, logic [CODE_W-1:0] code,
                                      int slot);
    event_t e;
    e.event_kind = kind;
    e.event_code = code;
    e.slot_index = SLOT_W'(slot);
    e.last_event = 1'b0;
    return e;
  endfunction

  // Work out the events a report causes, then replace the held report
  function automatic void diff_against_held(report_t rpt);
    slot_codes_t fresh;
    event_t      run[$];
    fresh = codes_of(rpt);
    if (rpt.modifier_bits != held_mods) run.push_back(mk_event(KIND_MODS, rpt.modifier_bits, 0));
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (fresh[i] != '0 && !code_present(held_keys, fresh[i]))
        run.push_back(mk_event(KIND_PRESS, fresh[i], i));
    end
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (held_keys[i] != '0 && !code_present(fresh, held_keys[i]))
        run.push_back(mk_event(KIND_RELEASE, held_keys[i], i));
    end
    if (run.size() > 0) run[run.size()-1].last_event = 1'b1;
    if (run.size() > longest_run) longest_run = run.size();
    foreach (run[i]) keyboard_events_due.push_back(run[i]);
    held_mods = rpt.modifier_bits;
    held_keys = fresh;
  endfunction

  // Random report: mostly a plausible step on from the last one
  function automatic report_t random_report();
    slot_codes_t       c;
    slot_codes_t       prev;
    logic [CODE_W-1:0] m;
    int                pick;
    int                r;
    int                rot;
    prev = codes_of(last_report);
    c    = prev;
    m    = last_report.modifier_bits;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
        r = $urandom_range(0, 9);
        if (r == 6 || r == 7) c[i] = '0;
        else if (r == 8) c[i] = CODE_W'($urandom_range(4, 12));
        else if (r == 9) c[i] = CODE_W'($urandom_range(0, 255));
      end
      r = $urandom_range(0, 9);
      if (r >= 6 && r < 9) m = m ^ (CODE_W'(1) << $urandom_range(0, 7));
      else if (r == 9) m = CODE_W'($urandom_range(0, 255));
    end else if (pick == 7) begin
      // same keys, other slots
      rot = $urandom_range(1, KEY_SLOTS - 1);
      for (int i = 0; i < KEY_SLOTS; i++) c[i] = prev[(i + rot) % KEY_SLOTS];
    end else begin
      // noise
      m = CODE_W'($urandom_range(0, 255));
      for (int i = 0; i < KEY_SLOTS; i++)
        c[i] = ($urandom_range(0, 3) == 0) ? '0 : CODE_W'($urandom_range(0, 255));
    end
    return make_report(m, c);
  endfunction

  // One report transfer; valid stays high between back-to-back reports
  task automatic send_report(input report_t rpt);
    int gap;
    gap = idle_on ? gap_len() : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    report_in <= rpt;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    diff_against_held(rpt);
    last_report = rpt;
    reports_sent++;
  endtask

  task automatic send_keys(input logic [CODE_W-1:0] mods, input logic [CODE_W-1:0] k0,
                           input logic [CODE_W-1:0] k1, input logic [CODE_W-1:0] k2,
                           input logic [CODE_W-1:0] k3, input logic [CODE_W-1:0] k4,
                           input logic [CODE_W-1:0] k5);
    slot_codes_t c;
    c = '{k0, k1, k2, k3, k4, k5};
    send_report(make_report(mods, c));
  endtask

  task automatic note_error(input string what, input bit have_want, input event_t want,
                            input event_t got);
    error_count++;
    if (error_count <= 10) begin
      if (have_want)
        $display("%0t: %s: expected kind %0d code %02h slot %0d last %0d, got kind %0d code %02h slot %0d last %0d",
                 $time, what, want.event_kind, want.event_code, want.slot_index,
                 want.last_event, got.event_kind, got.event_code, got.slot_index,
                 got.last_event);
      else
        $display("%0t: %s: kind %0d code %02h slot %0d last %0d", $time, what,
                 got.event_kind, got.event_code, got.slot_index, got.last_event);
    end
  endtask

  // Event checker
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_ready) input_stall_cycles++;
      if (evt_valid && evt_ready) begin
        events_seen++;
        if (keyboard_events_due.size() == 0) begin
          note_error("event with none due", 1'b0, event_out, event_out);
        end else begin
          want_evt = keyboard_events_due.pop_front();
          if (event_out.event_kind !== want_evt.event_kind ||
              event_out.event_code !== want_evt.event_code ||
              event_out.slot_index !== want_evt.slot_index ||
              event_out.last_event !== want_evt.last_event)
            note_error("event mismatch", 1'b1, want_evt, event_out);
        end
      end
    end
  end

  // Event receiver: random stalls plus a requested long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      evt_ready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      evt_ready <= 1'b0;
      stall_left--;
    end else begin
      evt_ready <= 1'b1;
      if (stalls_on && $urandom_range(0, 3) == 0) stall_left = gap_len();
    end
  end

  // Directed cases --------------------------------------------------------

  task automatic test_no_change();
    send_keys(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_keys(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_modifiers();
    send_keys(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_keys(8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_keys(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_keys(8'h55, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_keys(8'hAA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_keys(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_press_release();
    send_keys(8'h00, 8'h04, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00);
    // reordered keys plus one new one: a single press
    send_keys(8'h00, 8'h05, 8'h04, 8'h06, 8'h00, 8'h00, 8'h00);
    send_keys(8'hFF, 8'hFF, 8'hFE, 8'h80, 8'h7F, 8'h01, 8'h02);
    send_keys(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_repeated_codes();
    send_keys(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    // longest run: modifier, six presses, six releases
    send_keys(8'h3C, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04);
    send_keys(8'h3C, 8'h04, 8'h00, 8'h04, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_empty_slots();
    send_keys(8'h3C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h09);
    send_keys(8'h3C, 8'h09, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_keys(8'h3C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
  endtask

  // Receiver holds off while reports keep coming, so the input stalls
  task automatic test_backpressure();
    idle_on   = 1'b0;
    hold_left = 200;
    for (int n = 0; n < 20; n++) send_report(random_report());
  endtask

  task automatic test_random(input int count, input bit with_idle);
    idle_on   = with_idle;
    stalls_on = with_idle;
    for (int n = 0; n < count; n++) send_report(random_report());
  endtask

  // Main sequence
  initial begin
    rst                = 1'b1;
    req_valid         <= 1'b0;
    report_in         <= '0;
    evt_ready         <= 1'b0;
    held_mods          = '0;
    held_keys          = '{default: '0};
    last_report        = '0;
    error_count        = 0;
    reports_sent       = 0;
    events_seen        = 0;
    longest_run        = 0;
    input_stall_cycles = 0;
    idle_on            = 1'b0;
    stalls_on          = 1'b0;
    hold_left          = 0;
    stall_left         = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_no_change();
    test_modifiers();
    test_press_release();
    test_repeated_codes();
    test_empty_slots();
    test_backpressure();
    test_random(200, 1'b1);
    test_random(60, 1'b0);
    test_random(20, 1'b1);
    req_valid <= 1'b0;

    // drain
    while (keyboard_events_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (keyboard_events_due.size() != 0) begin
      error_count += keyboard_events_due.size();
      $display("%0d events still due at the end", keyboard_events_due.size());
    end

    $display("Sent %0d reports, checked %0d events, longest run %0d events",
             reports_sent, events_seen, longest_run);
    $display("Input was held off for %0d cycles under output back-pressure",
             input_stall_cycles);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #6000000;
    $display("Timed out with %0d events still due", keyboard_events_due.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/bkrd_pkg.sv
rtl/bkrd_lane.sv
rtl/bkrd_merge.sv
rtl/boot_keyboard_report_differ_unit.sv
test/tb.sv
